/* rtl/cdrom_sector_decoder_controller_macros.svh */
// assertion macros for the sector decoder controller
`ifndef CDROM_SECTOR_DECODER_CONTROLLER_MACROS_SVH
`define CDROM_SECTOR_DECODER_CONTROLLER_MACROS_SVH
`define CSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("violation");
`define CSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("violation");
`endif

/* rtl/csd_pkg.sv */
// shared types and constants of the sector decoder controller
`default_nettype none
package csd_pkg;
  localparam int unsigned BufDepth = 16384;
  localparam int unsigned BufAw = $clog2(BufDepth);
  localparam logic [11:0] SyncLen = 12'd2352;
  localparam logic [11:0] SyncLast = 12'd2351;

  typedef enum logic [2:0] {
    OP_ADDR = 3'd0, OP_WRITE = 3'd1, OP_READ = 3'd2,
    OP_DISC = 3'd3, OP_TICK = 3'd4, OP_RESUME = 3'd5
  } opcode_e;

  localparam logic [0:0] CFG_DMA_TICKS = 1'b0;
  localparam logic [0:0] CFG_DEC_LAT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_HDR, ST_TICK_DMA, ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;      // run the item's work in the exec state
    logic hdr_rd;    // issue one header byte read
    logic [1:0] hdr_idx;
    logic hdr_done;  // check header and post status
    logic dma;       // run the dma part of a tick
    logic clr_out;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic decode_fire; // tick ends the decode and loads header from buffer
    logic dec_last;    // tick ends the decode
  } sts_t;
endpackage
`default_nettype wire

/* rtl/csd_ctrl.sv */
// controller state machine of the sector decoder controller
`default_nettype none
module csd_ctrl import csd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_fire_i,
  input  wire logic is_tick_i,
  input  wire sts_t sts_i,
  input  wire logic out_fire_i,
  output logic      busy_o,
  output logic      out_valid_o,
  output ctl_t      ctl_o
);
  state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ctl_o = '0;
    busy_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (in_fire_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        ctl_o.clr_out = 1'b1;
        cnt_d = '0;
        if (is_tick_i && sts_i.decode_fire) state_d = ST_HDR;
        else if (is_tick_i) state_d = ST_TICK_DMA;
        else state_d = ST_OUT;
      end
      ST_HDR: begin
        // four reads, then a wait for the last read data, then the header check
        if (cnt_q < 3'd4) begin
          ctl_o.hdr_rd = 1'b1;
          ctl_o.hdr_idx = cnt_q[1:0];
        end
        if (cnt_q == 3'd5) begin
          ctl_o.hdr_done = 1'b1;
          state_d = ST_TICK_DMA;
        end
        cnt_d = cnt_q + 3'd1;
      end
      ST_TICK_DMA: begin
        ctl_o.dma = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_fire_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/csd_datapath.sv */
// registers, sync detector, buffer memory and dma engine
`default_nettype none
module csd_datapath import csd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_fire_i,
  input  wire logic [2:0] opcode_i,
  input  wire logic [7:0] bus_data_i,
  input  wire logic [7:0] disc_byte_i,
  input  wire logic [1:0] off_i,
  input  wire logic       host_ready_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire ctl_t       ctl_i,
  output sts_t            sts_o,
  output logic            is_tick_o,
  output logic [7:0]      read_data_o,
  output logic            dma_valid_o,
  output logic [7:0]      dma_byte_o,
  output logic            irq_o
);
  logic [2:0] op_q;
  logic [7:0] bus_q, db_q;
  logic [1:0] off_q;
  logic rdy_q;
  logic [7:0] rf_q [16];
  logic [7:0] ictl_q, dc0_q, dc1_q;
  logic [4:0] ptr_q;
  logic [15:0] dma_addr_q;
  logic [3:0] sync_q;
  logic [11:0] pos_q;
  logic [16:0] dcnt_q;
  logic act_q;
  logic [7:0] dcd_q;
  logic [7:0] tpb_q;
  logic [15:0] lat_q;
  logic [7:0] mem [BufDepth];
  logic [7:0] mem_rd_q;
  logic [7:0] hdr_q [4];
  logic [1:0] hidx_q;
  logic hvalid_q;
  logic [7:0] rd_q;
  logic dv_q;
  logic [7:0] db_out_q;
  logic [BufAw-1:0] hbase;

  assign is_tick_o = (op_q == OP_TICK);
  assign sts_o.dec_last = (dcnt_q == 17'd1);
  assign sts_o.decode_fire = (dcnt_q == 17'd1) && dc0_q[2];
  assign hbase = BufAw'({rf_q[9], rf_q[8]});

  function automatic logic hdr_ok(input logic [7:0] h0, h1, h2, h3);
    return h0 < 8'h74 && h0[3:0] < 4'hA && h1 < 8'h60 && h1[3:0] < 4'hA
      && h2 < 8'h75 && h2[3:0] < 4'hA && h3 < 8'd3;
  endfunction

  // buffer memory: one write port, one registered read port
  logic mem_we;
  logic [BufAw-1:0] mem_wa, mem_ra;
  logic mem_re;
  logic [15:0] wa;
  assign wa = {rf_q[11], rf_q[10]};
  assign mem_we = ctl_i.exec && op_q == OP_DISC && {dc0_q[7], dc0_q[2]} == 2'b11;
  assign mem_wa = wa[BufAw-1:0];
  always_comb begin
    mem_re = 1'b0;
    mem_ra = dma_addr_q[BufAw-1:0];
    if (ctl_i.hdr_rd) begin
      mem_re = 1'b1;
      mem_ra = hbase + BufAw'(ctl_i.hdr_idx);
    end else if (ctl_i.exec && op_q == OP_TICK) begin
      mem_re = 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= db_q;
    if (mem_re) mem_rd_q <= mem[mem_ra];
  end

  // dma byte read happens at exec; header reads overwrite, so keep it
  logic [7:0] dma_rd_q;
  logic dma_rd_pend_q;
  // decode ends on this tick; used when there is no buffer header load
  logic dec_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) rf_q[i] <= (i == 1) ? 8'hFF : 8'h00;
      ictl_q <= '0; dc0_q <= '0; dc1_q <= '0; ptr_q <= '0;
      dma_addr_q <= '0; sync_q <= '0; pos_q <= '0; dcnt_q <= '0;
      act_q <= 1'b0; dcd_q <= '0; tpb_q <= 8'd6; lat_q <= 16'd22030;
      op_q <= OP_ADDR; bus_q <= '0; db_q <= '0; off_q <= '0; rdy_q <= 1'b0;
      hvalid_q <= 1'b0; hidx_q <= '0; rd_q <= '0; dv_q <= 1'b0; db_out_q <= '0;
      dma_rd_pend_q <= 1'b0; dma_rd_q <= '0; dec_now_q <= 1'b0;
      for (int i = 0; i < 4; i++) hdr_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DMA_TICKS) tpb_q <= cfg_data_i[7:0];
        else lat_q <= cfg_data_i;
      end
      if (in_fire_i) begin
        op_q <= opcode_i; bus_q <= bus_data_i; db_q <= disc_byte_i;
        off_q <= off_i; rdy_q <= host_ready_i;
      end
      dma_rd_pend_q <= ctl_i.exec && op_q == OP_TICK;
      dec_now_q <= ctl_i.exec && op_q == OP_TICK && sts_o.dec_last;
      if (dma_rd_pend_q) dma_rd_q <= mem_rd_q;
      hvalid_q <= ctl_i.hdr_rd && !(ctl_i.exec);
      hidx_q <= ctl_i.hdr_idx;
      if (hvalid_q) hdr_q[hidx_q] <= mem_rd_q;
      if (ctl_i.clr_out) begin
        // a read sets its own value below
        if (op_q != OP_READ) rd_q <= '0;
        dv_q <= 1'b0; db_out_q <= '0;
      end
      if (ctl_i.exec) begin
        unique case (op_q)
          OP_ADDR: ptr_q <= bus_q[4:0];
          OP_WRITE: begin
            unique case (ptr_q)
              5'd0: begin
                rf_q[0] <= bus_q;
                if (ictl_q[0]) rf_q[1][2] <= 1'b0;
              end
              5'd1: begin
                ictl_q <= bus_q;
                if (!bus_q[0]) rf_q[1][2] <= 1'b1;
                if (!bus_q[1]) begin
                  rf_q[1][6] <= 1'b1; rf_q[1][3] <= 1'b1;
                  act_q <= 1'b0; dcd_q <= '0;
                end
              end
              5'd2: rf_q[2] <= bus_q;
              5'd3: rf_q[3] <= {4'h0, bus_q[3:0]};
              5'd4: dma_addr_q[7:0] <= bus_q;
              5'd5: dma_addr_q[15:8] <= bus_q;
              5'd6: if (ictl_q[1]) begin
                rf_q[1][3] <= 1'b0; act_q <= 1'b1; dcd_q <= '0;
              end
              5'd7: rf_q[1][6] <= 1'b1;
              5'd8: rf_q[10] <= bus_q;
              5'd9: rf_q[11] <= bus_q;
              5'd10: dc0_q <= bus_q;
              5'd11: dc1_q <= bus_q;
              5'd12: rf_q[8] <= bus_q;
              5'd13: rf_q[9] <= bus_q;
              5'd15: begin
                rf_q[1] <= 8'hFF; ictl_q <= '0; dc0_q <= '0; dc1_q <= '0;
                act_q <= 1'b0; dcd_q <= '0;
              end
              default: ;
            endcase
            if (ptr_q != 5'd0) ptr_q <= ptr_q + 5'd1;
          end
          OP_READ: begin
            if (ptr_q == 5'd0) rd_q <= 8'hFF;
            else begin
              rd_q <= ptr_q[4] ? 8'hFF : rf_q[ptr_q[3:0]];
              if (ptr_q == 5'd15) rf_q[1][5] <= 1'b1;
              ptr_q <= ptr_q + 5'd1;
            end
          end
          OP_DISC: begin : disc
            logic det, ign, ins;
            logic [7:0] s0, s3, i1;
            logic [11:0] np;
            logic [15:0] bs;
            det = 1'b0; ign = 1'b0;
            s0 = rf_q[12]; s3 = rf_q[15]; i1 = rf_q[1];
            if (db_q == 8'h00) begin
              if (sync_q == 4'd11 && off_q == 2'd3) begin
                if (dc1_q[6]) det = 1'b1; else ign = 1'b1;
                sync_q <= 4'd0;
              end else sync_q <= 4'd1;
            end else if (db_q == 8'hFF && sync_q != 4'd0) begin
              if (sync_q < 4'd12) sync_q <= sync_q + 4'd1;
            end else sync_q <= 4'd0;
            ins = dc1_q[7] && pos_q == SyncLast;
            if (pos_q < 12'd4 && {dc0_q[7], dc0_q[2]} == 2'b10)
              rf_q[4 + pos_q[1:0]] <= db_q;
            if (det || ins) begin
              s0 = s0 & ~8'h74;
              if (ins && !(det || ign)) s0 = s0 | 8'h20;
              if (det && pos_q != SyncLast) s0 = s0 | 8'h40;
              s0 = s0 & ~8'h81;
              pos_q <= '0;
              s3 = (s3 | 8'h80) & ~8'h40;
              i1 = i1 | 8'h20;
              if (dc0_q[7]) begin
                if (dc0_q[2]) begin
                  bs = wa + 16'd1 - 16'(SyncLen);
                  rf_q[8] <= bs[7:0]; rf_q[9] <= bs[15:8];
                end
                dcnt_q <= (lat_q == 16'd0) ? 17'd1 : {1'b0, lat_q};
              end
            end else begin
              np = pos_q + 12'd1;
              pos_q <= np;
              if (ign) s0 = s0 | 8'h04;
              if (np == SyncLen) s0 = s0 | 8'h10;
            end
            rf_q[12] <= s0; rf_q[15] <= s3; rf_q[1] <= i1;
            if (mem_we) begin
              rf_q[10] <= rf_q[10] + 8'd1;
              if (rf_q[10] == 8'hFF) rf_q[11] <= rf_q[11] + 8'd1;
            end
          end
          OP_TICK: begin
            if (dcnt_q != 17'd0) dcnt_q <= dcnt_q - 17'd1;
          end
          OP_RESUME: begin
            if (!act_q && ictl_q[1] && (rf_q[2] != 8'hFF || rf_q[3] != 8'hFF)) begin
              act_q <= 1'b1; dcd_q <= '0;
            end
          end
          default: ;
        endcase
      end
      if (ctl_i.hdr_done || (ctl_i.dma && dec_now_q && !dc0_q[2])) begin : dec
        logic [7:0] h0, h1, h2, h3;
        logic ok;
        h0 = dc0_q[2] ? hdr_q[0] : rf_q[4];
        h1 = dc0_q[2] ? hdr_q[1] : rf_q[5];
        h2 = dc0_q[2] ? hdr_q[2] : rf_q[6];
        h3 = dc0_q[2] ? mem_rd_q : rf_q[7];
        if (dc0_q[2]) begin
          rf_q[4] <= h0; rf_q[5] <= h1; rf_q[6] <= h2; rf_q[7] <= h3;
        end
        ok = hdr_ok(h0, h1, h2, h3) && !(rf_q[12][6] || rf_q[12][5]);
        rf_q[1][5] <= 1'b0;
        rf_q[15] <= (rf_q[15] & ~8'h80) | 8'h40;
        if (ok) begin
          if (dc0_q[2:0] != 3'd0) rf_q[12][7] <= 1'b1;
          rf_q[13] <= 8'h00; rf_q[14] <= 8'h10;
        end else begin
          if (dc0_q[2:0] != 3'd0) rf_q[12][0] <= 1'b1;
          rf_q[13] <= 8'hFF; rf_q[14] <= 8'hF2;
        end
      end
      if (ctl_i.dma && act_q) begin : dmab
        logic [7:0] c;
        logic run;
        c = (dcd_q != 8'd0) ? dcd_q - 8'd1 : 8'd0;
        run = 1'b1;
        if (c == 8'd0) begin
          dv_q <= 1'b1;
          // read data is still in the read register unless header reads came between
          db_out_q <= dma_rd_pend_q ? mem_rd_q : dma_rd_q;
          if (!rdy_q) begin
            run = 1'b0;
          end else begin
            c = (tpb_q == 8'd0) ? 8'd1 : tpb_q;
            dma_addr_q <= dma_addr_q + 16'd1;
            rf_q[2] <= rf_q[2] - 8'd1;
            if (rf_q[2] == 8'h00) begin
              rf_q[3] <= rf_q[3] - 8'd1;
              if (rf_q[3] == 8'h00) begin
                // byte count exhausted, end of transfer
                rf_q[1][6] <= 1'b0; rf_q[1][3] <= 1'b1;
                run = 1'b0;
              end
            end
          end
        end
        if (!run) c = '0;
        dcd_q <= c;
        act_q <= run;
      end
    end
  end

  assign read_data_o = rd_q;
  assign dma_valid_o = dv_q;
  assign dma_byte_o = db_out_q;
  assign irq_o = |(~rf_q[1] & ictl_q & 8'hE0);
endmodule
`default_nettype wire

/* rtl/cdrom_sector_decoder_controller.sv */
// top level of the sector decoder controller
//  channel  | dir | signals
//  s_axis   | in  | tdata: opcode, bus_data, disc_byte, sector_offset_low, host_ready
//  m_axis   | out | tdata: read_data, dma_valid, dma_byte, irq
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// a bus access or disc byte runs exec and out, a tick adds dma, one that ends a decode
// with buffer header load adds hdr: four header bytes go through the single buffer read port.
// one item is worked at a time; the result is held until taken.
// reset clears all control state; buffer contents are undefined until written.
`default_nettype none
`include "cdrom_sector_decoder_controller_macros.svh"
module cdrom_sector_decoder_controller import csd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[2:0], bus_data[10:3], disc_byte[18:11], sector_offset_low[20:19],
  // host_ready[21]
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[7:0], dma_valid[8], dma_byte[16:9], irq[17]
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  ctl_t ctl;
  sts_t sts;
  logic busy, is_tick, in_fire, out_fire;
  logic [7:0] rd, dbyte;
  logic dv, irq;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  csd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .is_tick_i(is_tick), .sts_i(sts),
    .out_fire_i(out_fire), .busy_o(busy), .out_valid_o(m_axis_tvalid), .ctl_o(ctl)
  );

  csd_datapath u_dp (
    .clk_i, .rst_ni, .in_fire_i(in_fire),
    .opcode_i(s_axis_tdata[2:0]), .bus_data_i(s_axis_tdata[10:3]),
    .disc_byte_i(s_axis_tdata[18:11]), .off_i(s_axis_tdata[20:19]),
    .host_ready_i(s_axis_tdata[21]),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .ctl_i(ctl), .sts_o(sts),
    .is_tick_o(is_tick), .read_data_o(rd), .dma_valid_o(dv),
    .dma_byte_o(dbyte), .irq_o(irq)
  );

  assign m_axis_tdata = {6'd0, irq, dbyte, dv, rd};

  `CSD_ASSERT_IMP(a_no_accept_busy, m_axis_tvalid, !s_axis_tready)
  `CSD_ASSERT_IMP(a_byte_zero, m_axis_tvalid && !m_axis_tdata[8], m_axis_tdata[16:9] == 8'd0)
  `CSD_ASSERT_NXT(a_accept_busy, in_fire, busy)
endmodule
`default_nettype wire

/* tb/cdrom_sector_decoder_controller_tb.sv */
// self-checking testbench of the sector decoder controller with a built-in predictor
`default_nettype none
module cdrom_sector_decoder_controller_tb;
  import csd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // pointer targets of register writes
  localparam logic [4:0] W_CMD = 5'd0, W_IFCTRL = 5'd1, W_DBCL = 5'd2, W_DBCH = 5'd3;
  localparam logic [4:0] W_DACL = 5'd4, W_DACH = 5'd5, W_DTTRG = 5'd6, W_DTACK = 5'd7;
  localparam logic [4:0] W_WAL = 5'd8, W_WAH = 5'd9, W_CTRL0 = 5'd10, W_CTRL1 = 5'd11;
  localparam logic [4:0] W_PTL = 5'd12, W_PTH = 5'd13, W_STAT2 = 5'd14, W_RESET = 5'd15;
  localparam logic [4:0] W_UNMAPPED = 5'd31;
  // register file slots
  localparam int R_CMD = 0, R_IFSTAT = 1, R_DBCL = 2, R_DBCH = 3, R_HEAD0 = 4;
  localparam int R_PTL = 8, R_PTH = 9, R_WAL = 10, R_WAH = 11;
  localparam int R_STAT0 = 12, R_STAT1 = 13, R_STAT2 = 14, R_STAT3 = 15;

  typedef struct packed {
    logic       ready;
    logic [1:0] off;
    logic [7:0] disc;
    logic [7:0] bus;
    logic [2:0] op;
  } item_t;

  typedef struct packed {
    logic       irq;
    logic [7:0] dbyte;
    logic       dvalid;
    logic [7:0] rdata;
  } result_t;

  typedef struct {
    logic [2:0] op;
    logic [7:0] bus;
    logic [7:0] disc;
    logic [1:0] off;
    logic       ready;
    logic       typed;
    logic [7:0] rdata;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  cdrom_sector_decoder_controller dut (.*);

  initial forever #2 clk_i = ~clk_i;

  // predicted state of the block
  logic [7:0]  regs [16];
  logic [7:0]  ifctl, dctl0, dctl1;
  logic [4:0]  reg_ptr;
  logic [15:0] dma_addr;
  logic [7:0]  sector_mem [BufDepth];
  logic [3:0]  sync_cnt;
  logic [11:0] sec_pos;
  logic [16:0] decode_left;
  logic        xfer_on;
  logic [7:0]  byte_wait;
  logic [7:0]  ticks_per_byte;
  logic [15:0] decode_latency;

  result_t     pending_results [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle = 0, recv_idle = 0;

  function automatic void halt_xfer();
    xfer_on = 1'b0;
    byte_wait = '0;
  endfunction

  function automatic void write_reg(logic [7:0] v);
    case (reg_ptr)
      W_CMD: begin
        regs[R_CMD] = v;
        if (ifctl[0]) regs[R_IFSTAT][2] = 1'b0;
      end
      W_IFCTRL: begin
        ifctl = v;
        if (!v[0]) regs[R_IFSTAT][2] = 1'b1;
        if (!v[1]) begin
          regs[R_IFSTAT] = regs[R_IFSTAT] | 8'h48;
          halt_xfer();
        end
      end
      W_DBCL: regs[R_DBCL] = v;
      W_DBCH: regs[R_DBCH] = {4'h0, v[3:0]};
      W_DACL: dma_addr[7:0] = v;
      W_DACH: dma_addr[15:8] = v;
      W_DTTRG: if (ifctl[1]) begin
        regs[R_IFSTAT][3] = 1'b0;
        xfer_on = 1'b1;
        byte_wait = '0;
      end
      W_DTACK: regs[R_IFSTAT][6] = 1'b1;
      W_WAL: regs[R_WAL] = v;
      W_WAH: regs[R_WAH] = v;
      W_CTRL0: dctl0 = v;
      W_CTRL1: dctl1 = v;
      W_PTL: regs[R_PTL] = v;
      W_PTH: regs[R_PTH] = v;
      W_RESET: begin
        regs[R_IFSTAT] = 8'hFF;
        ifctl = '0;
        dctl0 = '0;
        dctl1 = '0;
        halt_xfer();
      end
      default: ;
    endcase
    if (reg_ptr != W_CMD) reg_ptr = reg_ptr + 5'd1;
  endfunction

  function automatic logic [7:0] read_reg();
    logic [7:0] v;
    if (reg_ptr == W_CMD) return 8'hFF;
    if (reg_ptr == 5'(R_STAT3)) regs[R_IFSTAT][5] = 1'b1;
    v = reg_ptr[4] ? 8'hFF : regs[reg_ptr[3:0]];
    reg_ptr = reg_ptr + 5'd1;
    return v;
  endfunction

  function automatic void finish_decode();
    logic [15:0] a;
    logic        plausible;
    regs[R_IFSTAT][5] = 1'b0;
    regs[R_STAT3][7] = 1'b0;
    if (dctl0[2]) begin
      a = {regs[R_PTH], regs[R_PTL]};
      for (int i = 0; i < 4; i++) begin
        regs[R_HEAD0 + i] = sector_mem[a % BufDepth];
        a = a + 16'd1;
      end
    end
    plausible = regs[R_HEAD0] < 8'h74 && regs[R_HEAD0][3:0] < 4'hA
             && regs[R_HEAD0+1] < 8'h60 && regs[R_HEAD0+1][3:0] < 4'hA
             && regs[R_HEAD0+2] < 8'h75 && regs[R_HEAD0+2][3:0] < 4'hA
             && regs[R_HEAD0+3] < 8'd3 && (regs[R_STAT0] & 8'h60) == 8'h00;
    if (plausible) begin
      if (dctl0[2:0] != 3'd0) regs[R_STAT0][7] = 1'b1;
      regs[R_STAT1] = 8'h00;
      regs[R_STAT2] = 8'h10;
    end else begin
      if (dctl0[2:0] != 3'd0) regs[R_STAT0][0] = 1'b1;
      regs[R_STAT1] = 8'hFF;
      regs[R_STAT2] = 8'hF2;
    end
    regs[R_STAT3][6] = 1'b1;
  endfunction

  function automatic void run_tick(logic ready, inout result_t r);
    if (decode_left != '0) begin
      decode_left = decode_left - 17'd1;
      if (decode_left == '0) finish_decode();
    end
    if (!xfer_on) return;
    if (byte_wait != '0) byte_wait = byte_wait - 8'd1;
    if (byte_wait != '0) return;
    r.dvalid = 1'b1;
    r.dbyte = sector_mem[dma_addr % BufDepth];
    if (!ready) begin
      halt_xfer();
      return;
    end
    byte_wait = (ticks_per_byte == '0) ? 8'd1 : ticks_per_byte;
    dma_addr = dma_addr + 16'd1;
    regs[R_DBCL] = regs[R_DBCL] - 8'd1;
    if (regs[R_DBCL] == 8'hFF) begin
      regs[R_DBCH] = regs[R_DBCH] - 8'd1;
      if (regs[R_DBCH] == 8'hFF) begin
        regs[R_IFSTAT][6] = 1'b0;
        regs[R_IFSTAT][3] = 1'b1;
        halt_xfer();
      end
    end
  endfunction

  function automatic void take_disc_byte(logic [7:0] b, logic [1:0] off);
    logic [15:0] wa;
    logic        det, ign, ins;
    logic [7:0]  mode;
    logic [15:0] base;
    wa = {regs[R_WAH], regs[R_WAL]};
    det = 1'b0;
    ign = 1'b0;
    mode = dctl0 & 8'h84;
    if (b == 8'h00) begin
      if (sync_cnt == 4'd11 && off == 2'd3) begin
        if (dctl1[6]) det = 1'b1; else ign = 1'b1;
        sync_cnt = '0;
      end else begin
        sync_cnt = 4'd1;
      end
    end else if (b == 8'hFF && sync_cnt != '0) begin
      if (sync_cnt < 4'd12) sync_cnt = sync_cnt + 4'd1;
    end else begin
      sync_cnt = '0;
    end
    ins = dctl1[7] && sec_pos == SyncLast;
    if (sec_pos < 12'd4 && mode == 8'h80) regs[R_HEAD0 + sec_pos] = b;
    if (det || ins) begin
      regs[R_STAT0] = regs[R_STAT0] & ~8'h74;
      if (ins && !(det || ign)) regs[R_STAT0][5] = 1'b1;
      if (det && sec_pos != SyncLast) regs[R_STAT0][6] = 1'b1;
      sec_pos = '0;
      regs[R_STAT3][7] = 1'b1;
      regs[R_IFSTAT][5] = 1'b1;
      regs[R_STAT0] = regs[R_STAT0] & ~8'h81;
      regs[R_STAT3][6] = 1'b0;
      if (dctl0[7]) begin
        if (dctl0[2]) begin
          base = wa + 16'd1 - 16'(SyncLen);
          regs[R_PTL] = base[7:0];
          regs[R_PTH] = base[15:8];
        end
        decode_left = (decode_latency == '0) ? 17'd1 : 17'(decode_latency);
      end
    end else begin
      sec_pos = sec_pos + 12'd1;
      if (ign) regs[R_STAT0][2] = 1'b1;
      if (sec_pos == SyncLen) regs[R_STAT0][4] = 1'b1;
    end
    if (mode == 8'h84) begin
      sector_mem[wa % BufDepth] = b;
      regs[R_WAL] = regs[R_WAL] + 8'd1;
      if (regs[R_WAL] == 8'h00) regs[R_WAH] = regs[R_WAH] + 8'd1;
    end
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    r = '0;
    case (it.op)
      OP_ADDR: reg_ptr = it.bus[4:0];
      OP_WRITE: write_reg(it.bus);
      OP_READ: r.rdata = read_reg();
      OP_DISC: take_disc_byte(it.disc, it.off);
      OP_TICK: run_tick(it.ready, r);
      OP_RESUME: if (!xfer_on && ifctl[1]) begin
        if (regs[R_DBCL] != 8'hFF || regs[R_DBCH] != 8'hFF) begin
          xfer_on = 1'b1;
          byte_wait = '0;
        end
      end
      default: ;
    endcase
    r.irq = ((~regs[R_IFSTAT]) & ifctl & 8'hE0) != 8'h00;
    return r;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[17:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item %h", $realtime, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.rdata !== want.rdata) begin
          $display("%0t: read_data exp %h got %h", $realtime, want.rdata, got.rdata);
          mismatches++;
        end
        if (got.dvalid !== want.dvalid) begin
          $display("%0t: dma_valid exp %b got %b", $realtime, want.dvalid, got.dvalid);
          mismatches++;
        end
        if (got.dbyte !== want.dbyte) begin
          $display("%0t: dma_byte exp %h got %h", $realtime, want.dbyte, got.dbyte);
          mismatches++;
        end
        if (got.irq !== want.irq) begin
          $display("%0t: irq exp %b got %b", $realtime, want.irq, got.irq);
          mismatches++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send(item_t it, logic typed = 1'b0, logic [7:0] rd = '0);
    result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, 22'(it)};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_result(it);
    if (typed) r.rdata = rd;
    pending_results.push_back(r);
    items_sent++;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_op(logic [2:0] op, logic [7:0] bus = '0, logic [7:0] disc = '0,
                         logic [1:0] off = '0, logic ready = 1'b1);
    item_t it;
    it = '{ready: ready, off: off, disc: disc, bus: bus, op: op};
    send(it);
  endtask

  task automatic set_reg(logic [4:0] idx, logic [7:0] v);
    send_op(OP_ADDR, 8'(idx));
    send_op(OP_WRITE, v);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_timing(logic [7:0] per_byte, logic [15:0] latency);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_DMA_TICKS;
    cfg_data_i <= 16'(per_byte);
    @(posedge clk_i);
    cfg_idx_i <= CFG_DEC_LAT;
    cfg_data_i <= latency;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ticks_per_byte = per_byte;
    decode_latency = latency;
  endtask

  function automatic logic [7:0] bcd_byte(int unsigned hi_max);
    if ($urandom_range(9) == 0) return 8'($urandom);
    return {4'($urandom_range(hi_max)), 4'($urandom_range(9))};
  endfunction

  task automatic send_sync_burst();
    int unsigned ffs;
    ffs = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : 10;
    send_op(OP_DISC, 8'($urandom), 8'h00, 2'($urandom));
    repeat (ffs) send_op(OP_DISC, 8'($urandom), 8'hFF, 2'($urandom));
    send_op(OP_DISC, 8'($urandom), 8'h00, ($urandom_range(9) == 0) ? 2'($urandom) : 2'd3);
    send_op(OP_DISC, 8'($urandom), bcd_byte(7), 2'($urandom));
    send_op(OP_DISC, 8'($urandom), bcd_byte(5), 2'($urandom));
    send_op(OP_DISC, 8'($urandom), bcd_byte(7), 2'($urandom));
    send_op(OP_DISC, 8'($urandom), 8'($urandom_range(3)), 2'($urandom));
  endtask

  task automatic random_stimulus(int unsigned count);
    int unsigned stop_at;
    logic [7:0]  v;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1: send_sync_burst();
        2: begin
          case ($urandom_range(4))
            0: v = 8'h84;
            1: v = 8'h80;
            2: v = 8'h87;
            3: v = 8'h04;
            default: v = 8'($urandom);
          endcase
          set_reg(W_CTRL0, v);
          set_reg(W_CTRL1, ($urandom_range(3) == 0) ? 8'($urandom) : 8'hC0);
        end
        3: begin
          // set up and start a short transfer
          set_reg(W_IFCTRL, ($urandom_range(4) == 0) ? 8'($urandom) : 8'hE3);
          send_op(OP_WRITE, 8'($urandom_range(6)));
          send_op(OP_WRITE, ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
          send_op(OP_WRITE, 8'($urandom));
          send_op(OP_WRITE, 8'($urandom));
          send_op(OP_WRITE, 8'($urandom));
        end
        4, 5: repeat ($urandom_range(20, 1))
          send_op(OP_TICK, 8'($urandom), 8'($urandom), 2'($urandom), $urandom_range(9) != 0);
        6: begin
          send_op(OP_ADDR, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)));
          repeat ($urandom_range(4, 1)) send_op(OP_READ, 8'($urandom));
        end
        7: send_op(OP_RESUME, 8'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
        8: begin
          send_op(OP_ADDR, 8'($urandom));
          send_op(OP_WRITE, 8'($urandom));
        end
        default: send_op(3'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                         1'($urandom));
      endcase
    end
  endtask

  row_t script [] = '{
    '{OP_ADDR,   8'h00, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_READ,   8'h00, 8'h00, 2'd0, 1'b0, 1'b1, 8'hFF}, // command register
    '{OP_ADDR,   8'hFF, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_READ,   8'h00, 8'h00, 2'd0, 1'b0, 1'b1, 8'hFF}, // unmapped index
    '{OP_ADDR,   8'h0E, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  8'hAA, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_ADDR,   8'h01, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  8'hE3, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  8'h02, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  8'h00, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  8'hFF, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  8'hFF, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  8'h00, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_TICK,   8'h00, 8'h00, 2'd0, 1'b1, 1'b0, 8'h00},
    '{OP_TICK,   8'h00, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00}, // host not ready
    '{OP_RESUME, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_TICK,   8'hFF, 8'hFF, 2'd3, 1'b1, 1'b0, 8'h00},
    '{OP_TICK,   8'h00, 8'h00, 2'd0, 1'b1, 1'b0, 8'h00},
    '{3'd6,      8'hFF, 8'hFF, 2'd3, 1'b1, 1'b1, 8'h00},
    '{3'd7,      8'hFF, 8'hFF, 2'd3, 1'b1, 1'b1, 8'h00},
    '{OP_DISC,   8'h00, 8'h00, 2'd3, 1'b0, 1'b0, 8'h00},
    '{OP_DISC,   8'h00, 8'hFF, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_ADDR,   8'h0F, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00},
    '{OP_WRITE,  8'h00, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00}, // chip reset write
    '{OP_READ,   8'h00, 8'h00, 2'd0, 1'b0, 1'b0, 8'h00}
  };

  initial begin
    item_t it;
    foreach (regs[i]) regs[i] = '0;
    regs[R_IFSTAT] = 8'hFF;
    ifctl = '0;
    dctl0 = '0;
    dctl1 = '0;
    reg_ptr = '0;
    dma_addr = '0;
    sync_cnt = '0;
    sec_pos = '0;
    decode_left = '0;
    xfer_on = 1'b0;
    byte_wait = '0;
    ticks_per_byte = 8'd6;
    decode_latency = 16'd22030;
    // zero the buffer in both the block and the predictor so every entry holds a known byte
    for (int i = 0; i < BufDepth; i++) begin
      sector_mem[i] = '0;
      dut.u_dp.mem[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_timing(8'd1, 16'd1);
    send_idle = 14;
    recv_idle = 67;
    foreach (script[i]) begin
      it = '{ready: script[i].ready, off: script[i].off, disc: script[i].disc,
             bus: script[i].bus, op: script[i].op};
      send(it, script[i].typed, script[i].rdata);
      if (i == 12) begin
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
    end

    set_timing(8'd3, 16'd30);
    random_stimulus(250);
    send_idle = 67;
    recv_idle = 14;
    set_timing(8'd1, 16'd1);
    random_stimulus(250);
    send_idle = 0;
    recv_idle = 0;
    set_timing(8'd255, 16'd200);
    random_stimulus(250);

    drain();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
